/* hdl/ldfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfr_pkg
// Shared types, constants and helpers for the LCD decimal field refresh block.
// ----------------------------------------------------------------------------
package ldfr_pkg;

	localparam int READING_W = 20;
	localparam int CURSOR_W  = 3;
	localparam int BYTE_W    = 8;

	// value / 10000 as (value * DIV10K_MUL) >> DIV10K_SHIFT, exact below 2**20
	localparam int DIV10K_MUL_W = 23;
	localparam logic [DIV10K_MUL_W-1:0] DIV10K_MUL = 23'd6871948;
	localparam int DIV10K_SHIFT = 36;
	localparam logic [13:0] TEN_THOUSAND = 14'd10000;

	// value / 100 as (value * DIV100_MUL) >> DIV100_SHIFT, exact below 10000
	localparam int DIV100_MUL_W = 13;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SHIFT = 19;
	localparam logic [6:0] HUNDRED = 7'd100;

	localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;
	localparam logic [BYTE_W-1:0] ROW1_BASE    = 8'h40;
	localparam logic [BYTE_W-1:0] FIELD_COL    = 8'h08;
	localparam logic [BYTE_W-1:0] ASCII_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] ASCII_DOT    = 8'h2E;

	localparam logic RS_COMMAND = 1'b0;
	localparam logic RS_DATA    = 1'b1;

	// write slots within one nine-write run
	localparam int SLOT_W = 4;
	localparam logic [SLOT_W-1:0] WR_ADDR    = 4'd0;
	localparam logic [SLOT_W-1:0] WR_INT_HI  = 4'd1;
	localparam logic [SLOT_W-1:0] WR_INT_LO  = 4'd2;
	localparam logic [SLOT_W-1:0] WR_DOT     = 4'd3;
	localparam logic [SLOT_W-1:0] WR_FRAC_3  = 4'd4;
	localparam logic [SLOT_W-1:0] WR_FRAC_2  = 4'd5;
	localparam logic [SLOT_W-1:0] WR_FRAC_1  = 4'd6;
	localparam logic [SLOT_W-1:0] WR_FRAC_0  = 4'd7;
	localparam logic [SLOT_W-1:0] WR_CURSOR  = 4'd8;

	// two-digit groups, each 0..99
	typedef struct packed {
		logic                row;
		logic [CURSOR_W-1:0] cursor;
		logic [6:0]          int_pair;
		logic [6:0]          frac_hi;
		logic [6:0]          frac_lo;
	} digits_t;

	// split 0..99 into tens and units, packed as {tens, units}
	function automatic logic [7:0] split_pair(input logic [6:0] v);
		logic [3:0] tens;
		logic [7:0] prod;
		logic [6:0] units;
		tens = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (v >= 7'(k * 10))
				tens = tens + 4'd1;
		end
		prod = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
		units = v - prod[6:0];
		return {tens, units[3:0]};
	endfunction

	// column of the cursor digit; out-of-range codes sit on the leftmost digit
	function automatic logic [BYTE_W-1:0] cursor_col(input logic [CURSOR_W-1:0] c);
		logic [BYTE_W-1:0] col;
		case (c)
			3'd0: col = 8'h0E;
			3'd1: col = 8'h0D;
			3'd2: col = 8'h0C;
			3'd3: col = 8'h0B;
			3'd4: col = 8'h09;
			default: col = 8'h08;
		endcase
		return col;
	endfunction

endpackage

/* hdl/ldfr_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfr_req_if
// Request channel: row select, reading and cursor digit.
// ----------------------------------------------------------------------------
interface ldfr_req_if;
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic [ldfr_pkg::READING_W-1:0]   reading;
	logic [ldfr_pkg::CURSOR_W-1:0]    cursor_digit;

	modport source(output valid, cmd, reading, cursor_digit, input ready);
	modport sink(input valid, cmd, reading, cursor_digit, output ready);
endinterface

/* hdl/ldfr_wr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfr_wr_if
// LCD bus write channel: register select, data byte and end-of-run flag.
// ----------------------------------------------------------------------------
interface ldfr_wr_if;
	logic                          valid;
	logic                          ready;
	logic                          lcd_rs;
	logic [ldfr_pkg::BYTE_W-1:0]   lcd_byte;
	logic                          last;

	modport source(output valid, lcd_rs, lcd_byte, last, input ready);
	modport sink(input valid, lcd_rs, lcd_byte, last, output ready);
endinterface

/* hdl/ldfr_conv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfr_conv
// Register the request and split the reading into three two-digit groups.
// ----------------------------------------------------------------------------
module ldfr_conv (
	input  logic                clk,
	input  logic                arst_n,
	ldfr_req_if.sink            req,
	output logic                digits_valid,
	input  logic                digits_take,
	output ldfr_pkg::digits_t   digits
);

	localparam int PROD_W = ldfr_pkg::READING_W + ldfr_pkg::DIV10K_MUL_W;
	localparam int LOPROD_W = 14 + ldfr_pkg::DIV100_MUL_W;

	logic en;

	logic                                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic                                row_s1, row_s2, row_s3, row_s4, row_s5;
	logic [ldfr_pkg::CURSOR_W-1:0]       cur_s1, cur_s2, cur_s3, cur_s4, cur_s5;
	logic [ldfr_pkg::READING_W-1:0]      val_s1, val_s2;
	logic [6:0]                          qhi_s2;
	logic [13:0]                         lo_s3, lo_s4;
	logic [6:0]                          pair_s3, pair_s4, pair_s5;
	logic [6:0]                          loh_s4, loh_s5, lol_s5;

	logic [PROD_W-1:0]                   prod_hi;
	logic [ldfr_pkg::READING_W-1:0]      qhi_scaled;
	logic [ldfr_pkg::READING_W-1:0]      lo_full;
	logic [LOPROD_W-1:0]                 prod_lo;
	logic [13:0]                         loh_scaled;
	logic [13:0]                         lol_full;

	assign en = !vld_s5 || digits_take;
	assign req.ready = en;

	assign prod_hi    = PROD_W'(val_s1) * PROD_W'(ldfr_pkg::DIV10K_MUL);
	assign qhi_scaled = ldfr_pkg::READING_W'(qhi_s2) * ldfr_pkg::READING_W'(ldfr_pkg::TEN_THOUSAND);
	assign lo_full    = val_s2 - qhi_scaled;
	assign prod_lo    = LOPROD_W'(lo_s3) * LOPROD_W'(ldfr_pkg::DIV100_MUL);
	assign loh_scaled = 14'(loh_s4) * 14'(ldfr_pkg::HUNDRED);
	assign lol_full   = lo_s4 - loh_scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1  <= req.cmd;
			cur_s1  <= req.cursor_digit;
			val_s1  <= req.reading;

			row_s2  <= row_s1;
			cur_s2  <= cur_s1;
			val_s2  <= val_s1;
			qhi_s2  <= prod_hi[ldfr_pkg::DIV10K_SHIFT +: 7];

			row_s3  <= row_s2;
			cur_s3  <= cur_s2;
			lo_s3   <= lo_full[13:0];
			pair_s3 <= (qhi_s2 >= ldfr_pkg::HUNDRED) ? qhi_s2 - ldfr_pkg::HUNDRED : qhi_s2;

			row_s4  <= row_s3;
			cur_s4  <= cur_s3;
			lo_s4   <= lo_s3;
			pair_s4 <= pair_s3;
			loh_s4  <= prod_lo[ldfr_pkg::DIV100_SHIFT +: 7];

			row_s5  <= row_s4;
			cur_s5  <= cur_s4;
			pair_s5 <= pair_s4;
			loh_s5  <= loh_s4;
			lol_s5  <= lol_full[6:0];
		end
	end

	assign digits_valid     = vld_s5;
	assign digits.row       = row_s5;
	assign digits.cursor    = cur_s5;
	assign digits.int_pair  = pair_s5;
	assign digits.frac_hi   = loh_s5;
	assign digits.frac_lo   = lol_s5;

endmodule

/* hdl/ldfr_ser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldfr_ser
// Hold one converted request and issue its nine LCD bus writes in order.
// ----------------------------------------------------------------------------
module ldfr_ser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                digits_valid,
	output logic                digits_take,
	input  ldfr_pkg::digits_t   digits,
	ldfr_wr_if.source           wr
);

	logic                                 vld_q;
	logic [ldfr_pkg::SLOT_W-1:0]          slot_q;
	logic                                 row_q;
	logic [ldfr_pkg::CURSOR_W-1:0]        cur_q;
	logic [7:0]                           int_q, fhi_q, flo_q;
	logic [ldfr_pkg::BYTE_W-1:0]          base;
	logic                                 run_done;

	assign run_done    = wr.ready && (slot_q == ldfr_pkg::WR_CURSOR);
	assign digits_take = !vld_q || run_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			slot_q <= ldfr_pkg::WR_ADDR;
		end else if (digits_take) begin
			vld_q  <= digits_valid;
			slot_q <= ldfr_pkg::WR_ADDR;
		end else if (wr.ready) begin
			slot_q <= slot_q + ldfr_pkg::SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (digits_take && digits_valid) begin
			row_q <= digits.row;
			cur_q <= digits.cursor;
			int_q <= ldfr_pkg::split_pair(digits.int_pair);
			fhi_q <= ldfr_pkg::split_pair(digits.frac_hi);
			flo_q <= ldfr_pkg::split_pair(digits.frac_lo);
		end
	end

	assign base = ldfr_pkg::CMD_SET_ADDR | (row_q ? ldfr_pkg::ROW1_BASE : 8'h00);

	always_comb begin
		wr.lcd_rs   = ldfr_pkg::RS_DATA;
		wr.lcd_byte = ldfr_pkg::ASCII_ZERO;
		case (slot_q)
			ldfr_pkg::WR_ADDR: begin
				wr.lcd_rs   = ldfr_pkg::RS_COMMAND;
				wr.lcd_byte = base | ldfr_pkg::FIELD_COL;
			end
			ldfr_pkg::WR_INT_HI: wr.lcd_byte = ldfr_pkg::ASCII_ZERO | {4'h0, int_q[7:4]};
			ldfr_pkg::WR_INT_LO: wr.lcd_byte = ldfr_pkg::ASCII_ZERO | {4'h0, int_q[3:0]};
			ldfr_pkg::WR_DOT:    wr.lcd_byte = ldfr_pkg::ASCII_DOT;
			ldfr_pkg::WR_FRAC_3: wr.lcd_byte = ldfr_pkg::ASCII_ZERO | {4'h0, fhi_q[7:4]};
			ldfr_pkg::WR_FRAC_2: wr.lcd_byte = ldfr_pkg::ASCII_ZERO | {4'h0, fhi_q[3:0]};
			ldfr_pkg::WR_FRAC_1: wr.lcd_byte = ldfr_pkg::ASCII_ZERO | {4'h0, flo_q[7:4]};
			ldfr_pkg::WR_FRAC_0: wr.lcd_byte = ldfr_pkg::ASCII_ZERO | {4'h0, flo_q[3:0]};
			ldfr_pkg::WR_CURSOR: begin
				wr.lcd_rs   = ldfr_pkg::RS_COMMAND;
				wr.lcd_byte = base | ldfr_pkg::cursor_col(cur_q);
			end
			default: begin
				wr.lcd_rs   = ldfr_pkg::RS_COMMAND;
				wr.lcd_byte = ldfr_pkg::ASCII_ZERO;
			end
		endcase
	end

	assign wr.valid = vld_q;
	assign wr.last  = (slot_q == ldfr_pkg::WR_CURSOR);

endmodule

/* hdl/lcd_decimal_field_refresh_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_decimal_field_refresh_top
// Turn a reading request into the nine bus writes that redraw one LCD field.
// ----------------------------------------------------------------------------
// Usage:
//   req: one request per handshake (cmd = row, reading, cursor_digit).
//   wr:  bus writes, one per handshake: set-address to column 8 of the row,
//        seven ASCII bytes (two integer digits, '.', four fraction digits),
//        then a set-address that parks the cursor on the chosen digit; last
//        marks the ninth write. Only the low six decimal digits are shown.
//   Conversion: a five-stage pipeline of constant reciprocal multiplies;
//   its result is registered in the serializer before the first write
//   of a request is valid.
//   Throughput: one write per cycle while wr.ready is high; if the next
//   request is already converted, its first write follows the previous
//   last write with no gap. Up to five requests queue in the pipeline.
//   Stall: while wr.ready is low the current write holds; req.ready
//   drops while the last stage holds a result not yet taken.
//   Reset: arst_n clears all valid flags; no write is pending afterwards.
// ----------------------------------------------------------------------------
module lcd_decimal_field_refresh_top (
	input  logic        clk,
	input  logic        arst_n,
	ldfr_req_if.sink    req,
	ldfr_wr_if.source   wr
);

	logic                digits_valid;
	logic                digits_take;
	ldfr_pkg::digits_t   digits;

	ldfr_conv u_conv (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.digits_valid (digits_valid),
		.digits_take  (digits_take),
		.digits       (digits)
	);

	ldfr_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.digits_valid (digits_valid),
		.digits_take  (digits_take),
		.digits       (digits),
		.wr           (wr)
	);

`ifndef SYNTHESIS
	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid && wr.ready && !wr.last |=> wr.valid)
		else $error("write run broken before its last write");

	a_last_is_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid && wr.last |-> (wr.lcd_rs == ldfr_pkg::RS_COMMAND) && wr.lcd_byte[7])
		else $error("last write is not a set-address command");

	a_data_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid && (wr.lcd_rs == ldfr_pkg::RS_DATA) |->
		(wr.lcd_byte >= 8'h30 && wr.lcd_byte <= 8'h39) || (wr.lcd_byte == ldfr_pkg::ASCII_DOT))
		else $error("data write is not a digit or decimal point");

	a_next_starts_addr: assert property (@(posedge clk) disable iff (!arst_n)
		wr.valid && wr.ready && wr.last ##1 wr.valid |-> !wr.lcd_rs && !wr.last)
		else $error("run does not open with a set-address command");
`endif

endmodule
